// ----- src/mp2d_pkg.sv -----
// Shared types and constants for the 2x2 stride-2 max-pooling stream block.
// Used by mp2d_window and maxpool2d_stream_top; no dependencies.
`default_nettype none

package mp2d_pkg;

    localparam int MAX_SIZE     = 32;
    localparam int MAX_CHANNELS = 1024;

    localparam int SIZE_W  = 6;
    localparam int CHCNT_W = 11;
    localparam int POS_W   = 5;
    localparam int CHAN_W  = 10;
    localparam int OIDX_W  = 4;
    localparam int POOL_W  = 7;
    localparam int PIX_W   = 8;
    localparam int LINE_AW = $clog2(MAX_SIZE);

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = CHCNT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_SIZE      = 1'b0,
        CFG_CHANNEL_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              write_top;
        logic              start;
        logic              emit;
        logic [OIDX_W-1:0] orow;
        logic [OIDX_W-1:0] ocol;
        logic [CHAN_W-1:0] chan;
        logic              frame_end;
    } t_tag;

    typedef struct packed {
        logic              valid;
        logic [POOL_W-1:0] pooled;
        logic [OIDX_W-1:0] orow;
        logic [OIDX_W-1:0] ocol;
        logic [CHAN_W-1:0] chan;
        logic              frame_end;
    } t_res;

endpackage

`default_nettype wire

// ----- src/mp2d_window.sv -----
// Line store of the upper window row and the window maximum stage.
// Depends on mp2d_pkg.
`default_nettype none

module mp2d_window (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_accept,
    input  wire logic [mp2d_pkg::LINE_AW-1:0]        i_col,
    input  wire logic signed [mp2d_pkg::PIX_W-1:0]   i_pixel,
    input  wire mp2d_pkg::t_tag                      i_tag,
    output mp2d_pkg::t_res                           o_res
);

    logic [mp2d_pkg::PIX_W-1:0]        r_line [mp2d_pkg::MAX_SIZE];
    logic signed [mp2d_pkg::PIX_W-1:0] r_rd;
    logic                              r_s1_valid;
    logic signed [mp2d_pkg::PIX_W-1:0] r_s1_pix;
    mp2d_pkg::t_tag                    r_s1_tag;
    logic signed [mp2d_pkg::PIX_W-1:0] r_part;

    logic signed [mp2d_pkg::PIX_W-1:0] pair_max;
    logic signed [mp2d_pkg::PIX_W-1:0] best;

    // upper row written on even rows, read back under the lower row
    always_ff @(posedge i_clk) begin
        if (i_accept && i_tag.write_top) begin
            r_line[i_col] <= i_pixel;
        end
        if (i_en) begin
            r_rd <= $signed(r_line[i_col]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_pix <= i_pixel;
            r_s1_tag <= i_tag;
        end
        if (i_en && r_s1_valid && r_s1_tag.start) begin
            r_part <= pair_max;
        end
    end

    always_comb begin
        pair_max = (r_rd > r_s1_pix) ? r_rd : r_s1_pix;
        best     = (r_part > pair_max) ? r_part : pair_max;
        o_res.valid     = r_s1_valid & r_s1_tag.emit;
        o_res.pooled    = best[mp2d_pkg::PIX_W-1] ? '0 : best[mp2d_pkg::POOL_W-1:0];
        o_res.orow      = r_s1_tag.orow;
        o_res.ocol      = r_s1_tag.ocol;
        o_res.chan      = r_s1_tag.chan;
        o_res.frame_end = r_s1_tag.frame_end;
    end

endmodule

`default_nettype wire

// ----- src/maxpool2d_stream_top.sv -----
// Results leave on m_axis via the window stage and output registers. Throughput: one pixel
// per cycle unless the output is blocked, set by the line store read port plus one register
// holding the left-column pair maximum between the two lower-row beats of a window. Reset:
// s_axis_tready low, position counters zero, map_size 28, channel_count 6; line store
// contents undefined until written, no clearing pass. Depends on mp2d_pkg and mp2d_window.
`default_nettype none

module maxpool2d_stream_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [7:0]                           s_axis_tdata,  // [7:0] pixel
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [31:0]                               m_axis_tdata,  // [6:0] pooled,
                                                                     // [10:7] out_row,
                                                                     // [14:11] out_col,
                                                                     // [24:15] chan
    output logic                                      m_axis_tlast,  // frame_end
    input  wire logic                                 i_cfg_we,
    input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [mp2d_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [mp2d_pkg::SIZE_W-1:0]  r_map_size;
    logic [mp2d_pkg::CHCNT_W-1:0] r_chan_cnt;
    logic [mp2d_pkg::POS_W-1:0]   r_col, n_col;
    logic [mp2d_pkg::POS_W-1:0]   r_row, n_row;
    logic [mp2d_pkg::CHAN_W-1:0]  r_chan, n_chan;
    logic                         r_out_valid;
    mp2d_pkg::t_res               r_out;

    logic [mp2d_pkg::SIZE_W-1:0]  size_eff;
    logic [mp2d_pkg::CHCNT_W-1:0] chans_eff;
    logic [mp2d_pkg::POS_W-1:0]   nout_m1;
    logic                         last_col, last_row, last_chan;
    logic                         en, accept;
    mp2d_pkg::t_tag               tag;
    mp2d_pkg::t_res               res;

    always_comb begin
        if (r_map_size == '0) begin
            size_eff = mp2d_pkg::SIZE_W'(1);
        end else if (r_map_size > mp2d_pkg::SIZE_W'(mp2d_pkg::MAX_SIZE)) begin
            size_eff = mp2d_pkg::SIZE_W'(mp2d_pkg::MAX_SIZE);
        end else begin
            size_eff = r_map_size;
        end
        if (r_chan_cnt == '0) begin
            chans_eff = mp2d_pkg::CHCNT_W'(1);
        end else if (r_chan_cnt > mp2d_pkg::CHCNT_W'(mp2d_pkg::MAX_CHANNELS)) begin
            chans_eff = mp2d_pkg::CHCNT_W'(mp2d_pkg::MAX_CHANNELS);
        end else begin
            chans_eff = r_chan_cnt;
        end
    end

    assign nout_m1   = size_eff[mp2d_pkg::SIZE_W-1:1] - mp2d_pkg::POS_W'(1);
    assign last_col  = ({1'b0, r_col} == size_eff - mp2d_pkg::SIZE_W'(1));
    assign last_row  = ({1'b0, r_row} == size_eff - mp2d_pkg::SIZE_W'(1));
    assign last_chan = ({1'b0, r_chan} == chans_eff - mp2d_pkg::CHCNT_W'(1));

    // stall only when a result must enter a full, blocked output register
    assign en            = !(res.valid && r_out_valid && !m_axis_tready);
    assign s_axis_tready = en && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        tag.write_top = ~r_row[0];
        tag.start     = r_row[0] & ~r_col[0];
        tag.emit      = r_row[0] & r_col[0];
        tag.orow      = r_row[mp2d_pkg::POS_W-1:1];
        tag.ocol      = r_col[mp2d_pkg::POS_W-1:1];
        tag.chan      = r_chan;
        tag.frame_end = last_chan
                        && ({1'b0, r_row[mp2d_pkg::POS_W-1:1]} == nout_m1)
                        && ({1'b0, r_col[mp2d_pkg::POS_W-1:1]} == nout_m1);
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_chan = r_chan;
        if (last_col) begin
            n_col = '0;
            if (last_row) begin
                n_row  = '0;
                n_chan = last_chan ? '0 : r_chan + mp2d_pkg::CHAN_W'(1);
            end else begin
                n_row = r_row + mp2d_pkg::POS_W'(1);
            end
        end else begin
            n_col = r_col + mp2d_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_size <= mp2d_pkg::SIZE_W'(28);
            r_chan_cnt <= mp2d_pkg::CHCNT_W'(6);
            r_col      <= '0;
            r_row      <= '0;
            r_chan     <= '0;
        end else if (i_cfg_we) begin
            case (mp2d_pkg::t_cfg_idx'(i_cfg_idx))
                mp2d_pkg::CFG_MAP_SIZE: begin
                    r_map_size <= i_cfg_data[mp2d_pkg::SIZE_W-1:0];
                end
                mp2d_pkg::CFG_CHANNEL_COUNT: begin
                    r_chan_cnt <= i_cfg_data;
                end
                default: begin
                end
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_chan <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_chan <= n_chan;
        end
    end

    mp2d_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_accept(accept),
        .i_col   (r_col[mp2d_pkg::LINE_AW-1:0]),
        .i_pixel ($signed(s_axis_tdata)),
        .i_tag   (tag),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && res.valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.chan, r_out.ocol, r_out.orow, r_out.pooled};
    assign m_axis_tlast  = r_out.frame_end;

    a_col_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < size_eff)
        else $error("column position beyond map");

    a_chan_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_chan} < chans_eff)
        else $error("channel position beyond frame");

    a_frame_end_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> (r_out.orow == r_out.ocol))
        else $error("frame end off the last window");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("beat taken while a result is blocked");

endmodule

`default_nettype wire
